>>> rtl/tgi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle interpreter package
// Shared widths, command and status codes, sine table and step arithmetic.
// ----------------------------------------------------------------------------
package tgi_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned COORD_BITS_DEF  = 16;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned ANG_W      = 9;
  localparam int unsigned START_W    = 15;
  localparam int unsigned STROKE_W   = 12;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned SINE_W     = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = STROKE_W + SINE_W;
  localparam int unsigned STEP_W     = PROD_W - FRAC_W + 1;
  localparam int unsigned QIDX_W     = 7;

  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
  localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);

  // ASCII command characters
  localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_LBRACK = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_RBRACK = 8'h5D;
  localparam logic [SYM_W-1:0] SYM_UP_X   = 8'h58;
  localparam logic [SYM_W-1:0] SYM_UP_Y   = 8'h59;
  localparam logic [SYM_W-1:0] SYM_LO_F   = 8'h66;
  localparam logic [SYM_W-1:0] SYM_UP_F   = 8'h46;
  localparam logic [SYM_W-1:0] SYM_UP_A   = 8'h41;
  localparam logic [SYM_W-1:0] SYM_UP_B   = 8'h42;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TURN_ANGLE      = 3'd0,
    CFG_START_X         = 3'd1,
    CFG_START_Y         = 3'd2,
    CFG_STROKE_LENGTH   = 3'd3,
    CFG_INITIAL_HEADING = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_TURN_LEFT,
    OP_TURN_RIGHT,
    OP_PUSH,
    OP_POP,
    OP_MOVE,
    OP_DRAW,
    OP_UNKNOWN
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NEG_COORD   = 3'd1,
    ST_UNKNOWN_SYM = 3'd2,
    ST_STACK_FULL  = 3'd3,
    ST_STACK_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } tgi_cmd_t;

  // round(65536 * sin(d deg)), d = 0..90
  localparam logic [SINE_W-1:0] QSINE [0:90] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // 9-bit value to 0..359 (one subtract covers 360..511)
  function automatic logic [ANG_W-1:0] mod360(input logic [ANG_W-1:0] v);
    return (v >= DEG_360) ? v - DEG_360 : v;
  endfunction

  // sum of two angles already in 0..359
  function automatic logic [ANG_W-1:0] add_mod360(input logic [ANG_W-1:0] a,
                                                  input logic [ANG_W-1:0] b);
    logic [ANG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, DEG_360}) begin
      s = s - {1'b0, DEG_360};
    end
    return s[ANG_W-1:0];
  endfunction

  // trunc(len * sin(d)) for d in 0..359, quarter-wave folded
  function automatic logic signed [STEP_W-1:0] step_of(input logic [ANG_W-1:0]    d,
                                                       input logic [STROKE_W-1:0] len);
    logic              neg;
    logic [QIDX_W-1:0] idx;
    logic [PROD_W-1:0] p;
    logic [STEP_W-2:0] m;
    neg = (d > DEG_180);
    if (d <= DEG_90) begin
      idx = QIDX_W'(d);
    end else if (d <= DEG_180) begin
      idx = QIDX_W'(DEG_180 - d);
    end else if (d <= DEG_270) begin
      idx = QIDX_W'(d - DEG_180);
    end else begin
      idx = QIDX_W'(DEG_360 - d);
    end
    p = PROD_W'(len) * PROD_W'(QSINE[idx]);
    m = p[PROD_W-1:FRAC_W];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

>>> rtl/tgi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle interpreter channels
// Symbol channel and segment channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface tgi_in_if import tgi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             start_flag;

  modport source (output valid, symbol, start_flag, input ready);
  modport sink   (input valid, symbol, start_flag, output ready);
endinterface

interface tgi_out_if import tgi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    draw_valid;
  logic signed [OUT_W-1:0] from_x;
  logic signed [OUT_W-1:0] from_y;
  logic signed [OUT_W-1:0] to_x;
  logic signed [OUT_W-1:0] to_y;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, draw_valid, from_x, from_y, to_x, to_y, status,
                  input ready);
  modport sink   (input valid, draw_valid, from_x, from_y, to_x, to_y, status,
                  output ready);
endinterface

>>> rtl/tgi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module tgi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/tgi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle interpreter front end
// Takes symbol transfers, decodes them to commands, two-entry command queue.
// ----------------------------------------------------------------------------
module tgi_front import tgi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tgi_in_if.sink      in_chan,
  output logic        cmd_valid,
  output tgi_cmd_t    cmd,
  input  logic        cmd_ready
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  tgi_cmd_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push, pop;
  tgi_cmd_t          dec;

  always_comb begin
    dec.start = in_chan.start_flag;
    unique case (in_chan.symbol)
      SYM_PLUS:                     dec.op = OP_TURN_LEFT;
      SYM_MINUS:                    dec.op = OP_TURN_RIGHT;
      SYM_LBRACK:                   dec.op = OP_PUSH;
      SYM_RBRACK:                   dec.op = OP_POP;
      SYM_UP_X, SYM_UP_Y, SYM_LO_F: dec.op = OP_MOVE;
      SYM_UP_F, SYM_UP_A, SYM_UP_B: dec.op = OP_DRAW;
      default:                      dec.op = OP_UNKNOWN;
    endcase
  end

  assign in_chan.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (cnt_r != '0);
  assign cmd           = q_mem_r[rd_ptr_r];
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> rtl/tgi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle interpreter back end
// Executes commands: turtle state, save stack, step precompute, result register.
// ----------------------------------------------------------------------------
module tgi_back import tgi_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  tgi_cmd_t              cmd,
  output logic                  cmd_ready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tgi_out_if.source             out_chan
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned ENT_W = ANG_W + 2 * COORD_BITS;
  localparam int unsigned SUM_W = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 1;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  function automatic coord_t sat_start(input logic [START_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(C_MAX)) ? C_MAX : w[COORD_BITS-1:0];
  endfunction

  function automatic coord_t sat_add(input coord_t p, input logic signed [STEP_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = SUM_W'(p) + SUM_W'(s);
    if (t > SUM_W'(C_MAX)) begin
      return C_MAX;
    end else if (t < SUM_W'(C_MIN)) begin
      return C_MIN;
    end
    return t[COORD_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input coord_t c);
    logic signed [31:0] e;
    e = 32'(c);
    return e[OUT_W-1:0];
  endfunction

  // configuration, angles held already reduced mod 360
  logic [ANG_W-1:0]    turn_r, init_h_r;
  logic [START_W-1:0]  start_x_r, start_y_r;
  logic [STROKE_W-1:0] stroke_r;
  logic [ANG_W-1:0]    turn_neg;

  // turtle state
  coord_t           pos_x_r, pos_y_r, x_nxt, y_nxt;
  logic [ANG_W-1:0] heading_r, h_nxt;
  logic [CNT_W-1:0] count_r, cnt_nxt;
  logic [ENT_W-1:0] top_r, top_nxt;

  // step for current heading and for the start heading
  logic signed [STEP_W-1:0] step_x_r, step_y_r, init_sx_r, init_sy_r;

  // stack memory below the cached top entry
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_rdata, stack_q, byp_data_r;
  logic             byp_valid_r;
  logic [CNT_W-1:0] cnt_m1, cnt_nxt_m2;

  // execute view
  logic                     exec;
  coord_t                   cur_x, cur_y, mv_x, mv_y;
  logic [ANG_W-1:0]         cur_h;
  logic [CNT_W-1:0]         cur_cnt;
  logic signed [STEP_W-1:0] cur_sx, cur_sy;
  status_t                  status_nxt;
  logic                     draw_nxt;

  // result register
  logic             out_valid_r, out_draw_r;
  logic [OUT_W-1:0] out_fx_r, out_fy_r, out_tx_r, out_ty_r;
  status_t          out_status_r;

  assign cmd_ready = !out_valid_r || out_chan.ready;
  assign exec      = cmd_valid && cmd_ready;
  assign turn_neg  = (turn_r == '0) ? '0 : DEG_360 - turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r    <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      stroke_r  <= STROKE_W'(1);
      init_h_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_TURN_ANGLE:      turn_r    <= mod360(cfg_wdata[ANG_W-1:0]);
        CFG_START_X:         start_x_r <= cfg_wdata[START_W-1:0];
        CFG_START_Y:         start_y_r <= cfg_wdata[START_W-1:0];
        CFG_STROKE_LENGTH:   stroke_r  <= cfg_wdata[STROKE_W-1:0];
        CFG_INITIAL_HEADING: init_h_r  <= mod360(cfg_wdata[ANG_W-1:0]);
        default: ;
      endcase
    end
  end

  // start flag reloads before the symbol acts
  always_comb begin
    if (cmd.start) begin
      cur_x   = sat_start(start_x_r);
      cur_y   = sat_start(start_y_r);
      cur_h   = init_h_r;
      cur_cnt = '0;
      cur_sx  = init_sx_r;
      cur_sy  = init_sy_r;
    end else begin
      cur_x   = pos_x_r;
      cur_y   = pos_y_r;
      cur_h   = heading_r;
      cur_cnt = count_r;
      cur_sx  = step_x_r;
      cur_sy  = step_y_r;
    end
  end

  assign mv_x    = sat_add(cur_x, cur_sx);
  assign mv_y    = sat_add(cur_y, cur_sy);
  assign stack_q = byp_valid_r ? byp_data_r : ram_rdata;
  assign cnt_m1  = cur_cnt - CNT_W'(1);

  always_comb begin
    x_nxt      = pos_x_r;
    y_nxt      = pos_y_r;
    h_nxt      = heading_r;
    cnt_nxt    = count_r;
    top_nxt    = top_r;
    status_nxt = ST_OK;
    draw_nxt   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_m1[AW-1:0];
    if (exec) begin
      x_nxt   = cur_x;
      y_nxt   = cur_y;
      h_nxt   = cur_h;
      cnt_nxt = cur_cnt;
      unique case (cmd.op)
        OP_TURN_LEFT:  h_nxt = add_mod360(cur_h, turn_r);
        OP_TURN_RIGHT: h_nxt = add_mod360(cur_h, turn_neg);
        OP_PUSH: begin
          if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
            status_nxt = ST_STACK_FULL;
          end else begin
            // spill the cached top below the new one
            ram_we  = (cur_cnt != '0);
            top_nxt = {cur_h, cur_x, cur_y};
            cnt_nxt = cur_cnt + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cur_cnt == '0) begin
            status_nxt = ST_STACK_EMPTY;
          end else begin
            h_nxt   = top_r[ENT_W-1 -: ANG_W];
            x_nxt   = top_r[2*COORD_BITS-1 -: COORD_BITS];
            y_nxt   = top_r[COORD_BITS-1:0];
            top_nxt = stack_q;
            cnt_nxt = cnt_m1;
          end
        end
        OP_MOVE: begin
          x_nxt = mv_x;
          y_nxt = mv_y;
        end
        OP_DRAW: begin
          if (cur_x[COORD_BITS-1] || cur_y[COORD_BITS-1] ||
              mv_x[COORD_BITS-1] || mv_y[COORD_BITS-1]) begin
            status_nxt = ST_NEG_COORD;
          end else begin
            x_nxt    = mv_x;
            y_nxt    = mv_y;
            draw_nxt = 1'b1;
          end
        end
        default: status_nxt = ST_UNKNOWN_SYM;
      endcase
    end
  end

  // read one below the next top, so a pop finds it ready
  assign cnt_nxt_m2 = cnt_nxt - CNT_W'(2);
  assign ram_raddr  = cnt_nxt_m2[AW-1:0];

  tgi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      count_r     <= '0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r     <= x_nxt;
      pos_y_r     <= y_nxt;
      heading_r   <= h_nxt;
      count_r     <= cnt_nxt;
      byp_valid_r <= ram_we;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
    // lookup and multiply for the heading that takes effect next cycle
    step_x_r   <= step_of(add_mod360(h_nxt, DEG_90), stroke_r);
    step_y_r   <= step_of(h_nxt, stroke_r);
    init_sx_r  <= step_of(add_mod360(init_h_r, DEG_90), stroke_r);
    init_sy_r  <= step_of(init_h_r, stroke_r);
    if (exec) begin
      out_draw_r   <= draw_nxt;
      out_fx_r     <= to_out(cur_x);
      out_fy_r     <= to_out(cur_y);
      out_tx_r     <= to_out(x_nxt);
      out_ty_r     <= to_out(y_nxt);
      out_status_r <= status_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.draw_valid = out_draw_r;
  assign out_chan.from_x     = out_fx_r;
  assign out_chan.from_y     = out_fy_r;
  assign out_chan.to_x       = out_tx_r;
  assign out_chan.to_y       = out_ty_r;
  assign out_chan.status     = out_status_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd.op == OP_PUSH && !cmd.start && count_r == CNT_W'(STACK_DEPTH)
    |=> out_status_r == ST_STACK_FULL && count_r == $past(count_r))
    else $error("push on full stack not rejected");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    exec && cmd.op == OP_POP && (cmd.start || count_r == '0)
    |=> out_status_r == ST_STACK_EMPTY && count_r == '0)
    else $error("pop on empty stack not rejected");
`endif

endmodule

>>> rtl/turtle_graphics_interpreter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turtle graphics interpreter unit
// Runs one L-system turtle symbol per transfer and reports one segment result.
// ----------------------------------------------------------------------------
// Each symbol transfer yields exactly one result transfer, in order. The unit
// sustains one symbol per clock while results are taken: a symbol is decoded
// into a two-entry command queue, executed from the queue head when the back
// end is ready, and its result is registered in the output register and held
// there until taken, while new symbols keep flowing into the queue until it
// is full. This rate rests on the position loop (add and saturate of the
// precomputed step) and on the step registers, which hold length times cos/sin
// of the heading that takes effect next cycle (angle fold, quarter-wave table,
// 12x17 multiply). The save stack keeps its top entry in flops and the rest
// in a RAM; it needs no clearing after reset. Configuration writes are
// taken any time but are only meant while the unit is idle.
// ----------------------------------------------------------------------------
module turtle_graphics_interpreter_unit import tgi_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tgi_in_if.sink                in_chan,
  tgi_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // decoded command between the queue and the execute side
  logic     cmd_valid;
  logic     cmd_ready;
  tgi_cmd_t cmd;

  tgi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // back end stalls only on a held result; the queue absorbs that
  tgi_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_chan  (out_chan)
  );

endmodule
